// ===== design/nsam_pkg.sv =====
package nsam_pkg;

	localparam int POS_W = 12;
	localparam int CFG_W = 13;
	localparam int ADDR_W = 24;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DST_LEFT,
		REG_DST_TOP,
		REG_DST_WIDTH,
		REG_DST_HEIGHT,
		REG_CANVAS_WIDTH,
		REG_CANVAS_HEIGHT
	} cfg_reg_t;

endpackage

// ===== design/nsam_div.sv =====
module nsam_div #(
	parameter int DW = 13,
	parameter int FRAC = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        num,
	input  logic [DW-1:0]        den,
	output logic                 busy,
	output logic [DW+FRAC-1:0]   quot
);
	import nsam_pkg::*;

	localparam int QW = DW + FRAC;
	localparam int CNT_W = $clog2(QW + 1);

	logic [QW-1:0]    rq_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic             zero_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, rq_q[QW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rq_q <= {num, {FRAC{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			zero_q <= (den == '0);
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DW-1:0];
			end
			rq_q <= {rq_q[QW-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = zero_q ? '0 : rq_q;

endmodule

// ===== design/nsam_axis.sv =====
module nsam_axis #(
	parameter int DW = 13,
	parameter int FRAC = 16
) (
	input  logic                              clk,
	input  logic [nsam_pkg::POS_W-1:0]        pos,
	input  logic signed [nsam_pkg::CFG_W-1:0] edge_pos,
	input  logic [DW-1:0]                     dsize,
	input  logic [DW-1:0]                     csize,
	input  logic [DW-1:0]                     ssize,
	input  logic [DW+FRAC-1:0]                step,
	output logic                              hit,
	output logic [DW-1:0]                     idx
);
	import nsam_pkg::*;

	localparam int QW = DW + FRAC;
	localparam int PW = DW + QW;
	localparam int SW = ((DW > CFG_W) ? DW : CFG_W) + 2;

	logic signed [SW-1:0] pos_x;
	logic signed [SW-1:0] edge_x;
	logic signed [SW-1:0] end_x;
	logic signed [SW-1:0] off_x;
	logic                 in_span;

	logic          hit_s1;
	logic [DW-1:0] off_s1;
	logic          hit_s2;
	logic [PW-1:0] prod_s2;
	logic          hit_s3;
	logic [DW-1:0] idx_s3;

	logic [2*DW-1:0] quo;
	logic [DW-1:0]   idx_c;

	assign pos_x = $signed(SW'(pos));
	assign edge_x = SW'(edge_pos);
	assign end_x = edge_x + $signed(SW'(dsize));
	assign off_x = pos_x - edge_x;
	assign in_span = (ssize != '0) && (dsize != '0) && (csize != '0) &&
		(pos_x >= edge_x) && (pos_x < end_x) && (pos_x < $signed(SW'(csize)));

	assign quo = prod_s2[PW-1:FRAC];

	always_comb begin
		if (!hit_s2) begin
			idx_c = '0;
		end else if (quo >= (2*DW)'(ssize)) begin
			idx_c = ssize - DW'(1);
		end else begin
			idx_c = quo[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= in_span;
		off_s1 <= off_x[DW-1:0];
		hit_s2 <= hit_s1;
		prod_s2 <= PW'(off_s1) * PW'(step);
		hit_s3 <= hit_s2;
		idx_s3 <= idx_c;
	end

	assign hit = hit_s3;
	assign idx = idx_s3;

endmodule

// ===== design/nearest_scaler_address_map_core.sv =====
// Maps each canvas pixel to its nearest source pixel for a scaled blit. A
// transaction is taken on every clock in which start is high and busy is low,
// and its result appears on the result ports with done high once it has moved
// through the pipeline registers vld_s1 to vld_s4; the receiver cannot stall,
// so results must be captured in the cycle they are shown. After reset and
// after every configuration write, busy stays high while two bit-serial
// dividers recompute the horizontal and vertical steps.
module nearest_scaler_address_map_core #(
	parameter int MAX_DIM = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [nsam_pkg::POS_W-1:0]         pixel_col,
	input  logic [nsam_pkg::POS_W-1:0]         pixel_row,
	output logic                               busy,
	output logic                               done,
	output logic                               covered,
	output logic [nsam_pkg::POS_W-1:0]         source_col,
	output logic [nsam_pkg::POS_W-1:0]         source_row,
	output logic [nsam_pkg::ADDR_W-1:0]        source_address,
	output logic [nsam_pkg::ADDR_W-1:0]        canvas_address,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nsam_pkg::IDX_W-1:0]         cfg_index,
	input  logic [nsam_pkg::CFG_W-1:0]         cfg_data
);
	import nsam_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int QW = DW + FRAC_BITS;
	localparam int MW = (2 * DW + 1 > ADDR_W) ? 2 * DW + 1 : ADDR_W;
	localparam int CW = (POS_W + DW + 1 > ADDR_W) ? POS_W + DW + 1 : ADDR_W;

	logic [DW-1:0]           src_w_q;
	logic [DW-1:0]           src_h_q;
	logic [DW-1:0]           dst_w_q;
	logic [DW-1:0]           dst_h_q;
	logic [DW-1:0]           cv_w_q;
	logic [DW-1:0]           cv_h_q;
	logic signed [CFG_W-1:0] dst_l_q;
	logic signed [CFG_W-1:0] dst_t_q;
	logic                    pend_q;

	logic [DW-1:0] sat_v;
	logic          cfg_wr;
	logic          accept;
	logic          div_busy_h;
	logic          div_busy_v;
	logic [QW-1:0] step_h;
	logic [QW-1:0] step_v;

	logic          hit_x;
	logic          hit_y;
	logic [DW-1:0] idx_x;
	logic [DW-1:0] idx_y;
	logic          cov;
	logic [DW-1:0] sx;
	logic [DW-1:0] sy;
	logic [MW-1:0] saddr;

	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic              vld_s4;
	logic [POS_W-1:0]  row_s1;
	logic [POS_W-1:0]  col_s1;
	logic [CW-1:0]     cprod_s2;
	logic [POS_W-1:0]  col_s2;
	logic [ADDR_W-1:0] caddr_s3;
	logic              cov_s4;
	logic [POS_W-1:0]  scol_s4;
	logic [POS_W-1:0]  srow_s4;
	logic [ADDR_W-1:0] saddr_s4;
	logic [ADDR_W-1:0] caddr_s4;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign busy = pend_q || div_busy_h || div_busy_v;
	assign accept = start && !busy;

	always_comb begin
		if ({1'b0, cfg_data} > (CFG_W + 1)'(MAX_DIM)) begin
			sat_v = DW'(MAX_DIM);
		end else begin
			sat_v = DW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DW'(1);
			src_h_q <= DW'(1);
			dst_l_q <= '0;
			dst_t_q <= '0;
			dst_w_q <= DW'(1);
			dst_h_q <= DW'(1);
			cv_w_q <= '0;
			cv_h_q <= '0;
			pend_q <= 1'b1;
		end else begin
			pend_q <= cfg_wr;
			if (cfg_wr) begin
				case (cfg_reg_t'(cfg_index))
					REG_SRC_WIDTH: begin
						src_w_q <= sat_v;
					end
					REG_SRC_HEIGHT: begin
						src_h_q <= sat_v;
					end
					REG_DST_LEFT: begin
						dst_l_q <= cfg_data;
					end
					REG_DST_TOP: begin
						dst_t_q <= cfg_data;
					end
					REG_DST_WIDTH: begin
						dst_w_q <= sat_v;
					end
					REG_DST_HEIGHT: begin
						dst_h_q <= sat_v;
					end
					REG_CANVAS_WIDTH: begin
						cv_w_q <= sat_v;
					end
					REG_CANVAS_HEIGHT: begin
						cv_h_q <= sat_v;
					end
					default: begin
					end
				endcase
			end
		end
	end

	nsam_div #(.DW(DW), .FRAC(FRAC_BITS)) u_div_h (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pend_q),
		.num    (src_w_q),
		.den    (dst_w_q),
		.busy   (div_busy_h),
		.quot   (step_h)
	);

	nsam_div #(.DW(DW), .FRAC(FRAC_BITS)) u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pend_q),
		.num    (src_h_q),
		.den    (dst_h_q),
		.busy   (div_busy_v),
		.quot   (step_v)
	);

	nsam_axis #(.DW(DW), .FRAC(FRAC_BITS)) u_axis_x (
		.clk      (clk),
		.pos      (pixel_col),
		.edge_pos (dst_l_q),
		.dsize    (dst_w_q),
		.csize    (cv_w_q),
		.ssize    (src_w_q),
		.step     (step_h),
		.hit      (hit_x),
		.idx      (idx_x)
	);

	nsam_axis #(.DW(DW), .FRAC(FRAC_BITS)) u_axis_y (
		.clk      (clk),
		.pos      (pixel_row),
		.edge_pos (dst_t_q),
		.dsize    (dst_h_q),
		.csize    (cv_h_q),
		.ssize    (src_h_q),
		.step     (step_v),
		.hit      (hit_y),
		.idx      (idx_y)
	);

	assign cov = hit_x && hit_y;
	assign sx = cov ? idx_x : '0;
	assign sy = cov ? idx_y : '0;
	assign saddr = MW'(sy) * MW'(src_w_q) + MW'(sx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= pixel_row;
		col_s1 <= pixel_col;
		cprod_s2 <= CW'(row_s1) * CW'(cv_w_q);
		col_s2 <= col_s1;
		caddr_s3 <= ADDR_W'(cprod_s2 + CW'(col_s2));
		cov_s4 <= cov;
		scol_s4 <= POS_W'(sx);
		srow_s4 <= POS_W'(sy);
		saddr_s4 <= ADDR_W'(saddr);
		caddr_s4 <= caddr_s3;
	end

	assign done = vld_s4;
	assign covered = cov_s4;
	assign source_col = scol_s4;
	assign source_row = srow_s4;
	assign source_address = saddr_s4;
	assign canvas_address = caddr_s4;

	// Every accepted transaction produces its result with done high once it has passed vld_s1 to vld_s4.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted transaction did not complete in four cycles");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> busy)
		else $error("configuration write did not start a step recompute");

	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !covered) |-> (source_col == '0 && source_row == '0 &&
		source_address == '0))
		else $error("uncovered pixel returned a nonzero source position");

	a_col_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && covered) |-> ((DW + POS_W)'(source_col) < (DW + POS_W)'(src_w_q)))
		else $error("source column not clamped below source width");

endmodule
